>>> rtl/mtr_pkg.sv
// mtr_pkg: shared types and constants for the media timestamp rebaser.
// Beat payload structs, register map codes and default sizing.
// No dependencies.
`timescale 1ns / 1ps

package mtr_pkg;

	localparam int unsigned STREAM_COUNT_DEF = 16;
	localparam int unsigned STREAM_W = 4;
	localparam int unsigned TIME_W = 63;
	localparam int unsigned MASK_W = 16;
	localparam int unsigned APB_DATA_W = 64;
	localparam int unsigned PADDR_W = 5;
	localparam int unsigned REG_ADDR_LSB = 3;
	localparam int unsigned REG_IDX_W = PADDR_W - REG_ADDR_LSB;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
	localparam logic [MASK_W-1:0] MASK_RESET = MASK_W'(1);

	typedef enum logic [REG_IDX_W-1:0] {
		REG_WINDOW_START = 2'd0,
		REG_WINDOW_END = 2'd1,
		REG_ENABLE_MASK = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [STREAM_W-1:0] stream_number;
		logic time_valid;
		logic signed [63:0] sample_time;
		logic duration_valid;
		logic signed [63:0] sample_duration;
		logic decode_valid;
		logic [63:0] decode_time;
	} sample_t;

	typedef struct packed {
		logic accepted;
		logic [STREAM_W-1:0] out_stream;
		logic [TIME_W-1:0] out_time;
		logic [TIME_W-1:0] out_duration;
		logic out_decode_valid;
		logic [TIME_W-1:0] out_decode_time;
		logic discontinuity;
	} result_t;

endpackage

>>> rtl/mtr_ram.sv
// mtr_ram: generic single write port, single read port RAM, registered read.
// Read and write of one address at the same edge returns the old data.
// No dependencies.
`timescale 1ns / 1ps

module mtr_ram #(
	parameter int unsigned WIDTH = 63,
	parameter int unsigned DEPTH = 16
) (
	input  logic clk,
	input  logic wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/media_timestamp_rebaser.sv
// media_timestamp_rebaser: per-sample timestamp rebasing for a media mux.
// Pipeline: accept edge -> s1 register -> result register.
// Throughput: one beat per cycle unless result stalls; history per stream
// in two RAMs, one-entry write bypass: back-to-back same-stream beats exact.
// Reset (arst_n low): config to defaults, history marked empty through
// per-stream seen bits, no clearing pass; payload registers are not reset.
`timescale 1ns / 1ps

module media_timestamp_rebaser #(
	parameter int unsigned STREAM_COUNT = mtr_pkg::STREAM_COUNT_DEF
) (
	input  logic clk,
	input  logic arst_n,
	// APB-style register port
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [mtr_pkg::PADDR_W-1:0] paddr,
	input  logic [mtr_pkg::APB_DATA_W-1:0] pwdata,
	output logic [mtr_pkg::APB_DATA_W-1:0] prdata,
	output logic pready,
	// sample channel
	input  logic sample_valid,
	output logic sample_ready,
	input  mtr_pkg::sample_t sample,
	// result channel
	output logic result_valid,
	input  logic result_ready,
	output mtr_pkg::result_t result
);

	localparam int unsigned AW = (STREAM_COUNT > 1) ? $clog2(STREAM_COUNT) : 1;
	localparam int unsigned RAM_DEPTH = 1 << AW;
	localparam int unsigned TW = mtr_pkg::TIME_W;

	// Force v strictly above prev when there is a prev; saturate at the top.
	function automatic logic [TW-1:0] force_rising(
		input logic [TW-1:0] v,
		input logic seen,
		input logic [TW-1:0] prev
	);
		logic [TW-1:0] r;
		r = v;
		if (seen && (v <= prev)) begin
			r = (prev == mtr_pkg::TIME_MAX) ? prev : prev + TW'(1);
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [TW-1:0] window_start_q;
	logic [TW-1:0] window_end_q;
	logic [mtr_pkg::MASK_W-1:0] enable_mask_q;
	mtr_pkg::reg_idx_t reg_idx;
	logic cfg_wr;

	assign pready = 1'b1;
	assign reg_idx = mtr_pkg::reg_idx_t'(paddr[mtr_pkg::PADDR_W-1:mtr_pkg::REG_ADDR_LSB]);
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_start_q <= '0;
			window_end_q <= '0;
			enable_mask_q <= mtr_pkg::MASK_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				mtr_pkg::REG_WINDOW_START: window_start_q <= pwdata[TW-1:0];
				mtr_pkg::REG_WINDOW_END: window_end_q <= pwdata[TW-1:0];
				mtr_pkg::REG_ENABLE_MASK: enable_mask_q <= pwdata[mtr_pkg::MASK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			mtr_pkg::REG_WINDOW_START: prdata = {1'b0, window_start_q};
			mtr_pkg::REG_WINDOW_END: prdata = {1'b0, window_end_q};
			mtr_pkg::REG_ENABLE_MASK:
				prdata = {{(mtr_pkg::APB_DATA_W - mtr_pkg::MASK_W){1'b0}}, enable_mask_q};
			default: prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Handshake: s1 holds the beat under work, result_q the finished one.
	// ------------------------------------------------------------------
	logic valid_s1;
	mtr_pkg::sample_t sample_s1;
	logic [AW-1:0] addr_s1;
	logic result_valid_q;
	mtr_pkg::result_t result_q;
	logic out_load;
	logic commit;
	logic take;

	assign out_load = !result_valid_q || result_ready;
	assign sample_ready = !valid_s1 || out_load;
	assign take = sample_valid && sample_ready;
	assign commit = valid_s1 && out_load;

	// stream number widened then cut to the RAM address width
	logic [AW+mtr_pkg::STREAM_W-1:0] stream_ext;
	logic [AW-1:0] rd_addr;
	assign stream_ext = {{AW{1'b0}}, sample.stream_number};
	assign rd_addr = stream_ext[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sample_s1 <= sample;
			addr_s1 <= rd_addr;
		end
	end

	// ------------------------------------------------------------------
	// Per-stream history: RAM read issued at accept, lands with s1.
	// ------------------------------------------------------------------
	logic [TW-1:0] pres_rd;
	logic [TW-1:0] dec_rd;
	logic pres_wr;
	logic dec_wr;
	logic [TW-1:0] pres_new;
	logic [TW-1:0] dec_new;

	mtr_ram #(.WIDTH(TW), .DEPTH(RAM_DEPTH)) u_pres_ram (
		.clk(clk),
		.wr_en(pres_wr),
		.wr_addr(addr_s1),
		.wr_data(pres_new),
		.rd_en(take),
		.rd_addr(rd_addr),
		.rd_data(pres_rd)
	);

	mtr_ram #(.WIDTH(TW), .DEPTH(RAM_DEPTH)) u_dec_ram (
		.clk(clk),
		.wr_en(dec_wr),
		.wr_addr(addr_s1),
		.wr_data(dec_new),
		.rd_en(take),
		.rd_addr(rd_addr),
		.rd_data(dec_rd)
	);

	// seen bits stand in for the "none yet" reset of the history
	logic [RAM_DEPTH-1:0] pres_seen_q;
	logic [RAM_DEPTH-1:0] dec_seen_q;

	// last write of each RAM, covers a read that raced that write
	logic byp_pres_valid_q;
	logic [AW-1:0] byp_pres_addr_q;
	logic [TW-1:0] byp_pres_data_q;
	logic byp_dec_valid_q;
	logic [AW-1:0] byp_dec_addr_q;
	logic [TW-1:0] byp_dec_data_q;
	logic video_pending_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pres_seen_q <= '0;
			dec_seen_q <= '0;
			byp_pres_valid_q <= 1'b0;
			byp_dec_valid_q <= 1'b0;
			video_pending_q <= 1'b1;
		end else begin
			if (pres_wr) begin
				pres_seen_q[addr_s1] <= 1'b1;
				byp_pres_valid_q <= 1'b1;
			end
			if (dec_wr) begin
				dec_seen_q[addr_s1] <= 1'b1;
				byp_dec_valid_q <= 1'b1;
			end
			if (pres_wr && (sample_s1.stream_number == '0)) begin
				video_pending_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pres_wr) begin
			byp_pres_addr_q <= addr_s1;
			byp_pres_data_q <= pres_new;
		end
		if (dec_wr) begin
			byp_dec_addr_q <= addr_s1;
			byp_dec_data_q <= dec_new;
		end
	end

	// ------------------------------------------------------------------
	// s1 datapath
	// ------------------------------------------------------------------
	logic in_range;
	logic enabled;
	logic [TW-1:0] t_low;
	logic in_window;
	logic keep;
	logic [TW-1:0] pres_prev;
	logic [TW-1:0] dec_prev;
	logic [TW-1:0] rebased;
	logic [TW-1:0] dur_raw;
	logic [TW-1:0] span;
	logic [TW-1:0] dur_clamped;
	logic [63:0] dts_diff;
	logic [TW-1:0] dts_base;
	mtr_pkg::result_t res_next;

	assign in_range = 32'(sample_s1.stream_number) < STREAM_COUNT;
	assign enabled = enable_mask_q[sample_s1.stream_number];
	assign t_low = sample_s1.sample_time[TW-1:0];
	// negative times never reach the window
	assign in_window = sample_s1.time_valid && !sample_s1.sample_time[63]
		&& (t_low >= window_start_q) && (t_low < window_end_q);
	assign keep = in_range && enabled && in_window;

	assign pres_prev = (byp_pres_valid_q && (byp_pres_addr_q == addr_s1))
		? byp_pres_data_q : pres_rd;
	assign dec_prev = (byp_dec_valid_q && (byp_dec_addr_q == addr_s1))
		? byp_dec_data_q : dec_rd;

	assign rebased = t_low - window_start_q;
	assign pres_new = force_rising(rebased, pres_seen_q[addr_s1], pres_prev);

	// duration: missing, zero or negative counts as 1; clip at window end
	assign dur_raw = (!sample_s1.duration_valid || sample_s1.sample_duration[63]
		|| (sample_s1.sample_duration == '0))
		? TW'(1) : sample_s1.sample_duration[TW-1:0];
	assign span = window_end_q - t_low;
	assign dur_clamped = (dur_raw > span) ? span : dur_raw;

	// decode time: floor at zero, saturate above the 63-bit range
	assign dts_diff = sample_s1.decode_time - {1'b0, window_start_q};
	always_comb begin
		if (sample_s1.decode_time <= {1'b0, window_start_q}) begin
			dts_base = '0;
		end else if (dts_diff[63]) begin
			dts_base = mtr_pkg::TIME_MAX;
		end else begin
			dts_base = dts_diff[TW-1:0];
		end
	end
	assign dec_new = force_rising(dts_base, dec_seen_q[addr_s1], dec_prev);

	assign pres_wr = commit && keep;
	assign dec_wr = commit && keep && sample_s1.decode_valid;

	always_comb begin
		res_next = '0;
		res_next.out_stream = sample_s1.stream_number;
		if (keep) begin
			res_next.accepted = 1'b1;
			res_next.out_time = pres_new;
			res_next.out_duration = dur_clamped;
			res_next.out_decode_valid = sample_s1.decode_valid;
			res_next.out_decode_time = sample_s1.decode_valid ? dec_new : '0;
			res_next.discontinuity = (sample_s1.stream_number == '0) && video_pending_q;
		end
	end

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			result_q <= res_next;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule
